/* rtl/lbc_pkg.sv */
// Shared constants and types for the LRU block cache.
`timescale 1ns / 1ps
package lbc_pkg;
	localparam int CAPACITY     = 64;
	localparam int PAYLOAD_BITS = 64;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int CFG_W        = 7;
	localparam int DISK_W       = 8;
	localparam int BLOCK_W      = 16;
	localparam int DATA_W       = 64;
	localparam int SLOT_W       = 6;
	localparam int STAMP_W      = 32;
	localparam int KEY_W        = STAMP_W + 1;
	localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(64);

	localparam logic ACT_PUT = 1'b0;
	localparam logic ACT_GET = 1'b1;

	typedef struct packed {
		logic [DISK_W-1:0]  disk;
		logic [BLOCK_W-1:0] block;
		logic [STAMP_W-1:0] stamp;
	} tag_entry_t;

	localparam int TAG_ENTRY_W = $bits(tag_entry_t);
endpackage

/* rtl/lru_block_cache_unit.sv */
// Top level of the fully associative LRU block cache.
// With n searched entries (entries_in_use clamped to 1..64), each request scans
// n tag entries, then fetches and finishes; a new request is accepted only
// once the previous result has been committed to the output register.
// The scan walks the tag RAM read port one entry a cycle.
// Reset clears the valid bits, the use clock and sets entries_in_use to 64;
// RAM contents are left as they are and are never used before being written.
`timescale 1ns / 1ps
module lru_block_cache_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lbc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [lbc_pkg::DISK_W-1:0]         disk_id,
	input  logic [lbc_pkg::BLOCK_W-1:0]        block_id,
	input  logic [lbc_pkg::DATA_W-1:0]         write_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic [lbc_pkg::DATA_W-1:0]         read_data,
	output logic [lbc_pkg::SLOT_W-1:0]         slot
);
	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FETCH  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam int IDX_W = lbc_pkg::IDX_W;
	localparam int CNT_W = lbc_pkg::CNT_W;
	localparam int KEY_W = lbc_pkg::KEY_W;

	logic [1:0]                        state_q;
	logic [lbc_pkg::CFG_W-1:0]         entries_q;
	logic [lbc_pkg::CAPACITY-1:0]      valid_q;
	logic [lbc_pkg::STAMP_W-1:0]       use_clock_q;

	// Latched request.
	logic                              act_q;
	logic [lbc_pkg::DISK_W-1:0]        disk_q;
	logic [lbc_pkg::BLOCK_W-1:0]       block_q;
	logic [lbc_pkg::PAYLOAD_BITS-1:0]  data_q;
	logic [CNT_W-1:0]                  n_q;

	// Scan bookkeeping: the issue counter leads the compare by the RAM read register.
	logic [CNT_W-1:0]                  iss_q;
	logic                              ev_vld_q;
	logic [IDX_W-1:0]                  ev_idx_q;
	logic                              found_q;
	logic [IDX_W-1:0]                  hit_idx_q;
	logic [KEY_W-1:0]                  best_q;
	logic [IDX_W-1:0]                  victim_q;

	// Output register.
	logic                              out_valid_q;
	logic                              hit_q;
	logic [lbc_pkg::DATA_W-1:0]        read_data_q;
	logic [lbc_pkg::SLOT_W-1:0]        slot_q;

	logic                              in_beat;
	logic                              issue;
	logic [CNT_W-1:0]                  n_clamped;
	lbc_pkg::tag_entry_t               tag_rd;
	lbc_pkg::tag_entry_t               tag_wr;
	logic [lbc_pkg::TAG_ENTRY_W-1:0]   tag_rd_raw;
	logic [lbc_pkg::PAYLOAD_BITS-1:0]  pay_rd;
	logic                              tag_match;
	logic [KEY_W-1:0]                  ev_key;
	logic                              older;
	logic [IDX_W-1:0]                  target;
	logic                              commit;
	logic                              get_miss;
	logic                              tag_we;
	logic                              pay_we;
	logic                              pay_re;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;

	// An entry count of zero behaves as one, and anything above the capacity
	// behaves as the full capacity.
	always_comb begin
		if (entries_q == '0) begin
			n_clamped = CNT_W'(1);
		end else if (32'(entries_q) > 32'(lbc_pkg::CAPACITY)) begin
			n_clamped = CNT_W'(lbc_pkg::CAPACITY);
		end else begin
			n_clamped = CNT_W'(entries_q);
		end
	end

	// The scan reads one tag word per cycle; the compare of that word happens
	// in the following cycle, when the registered read data is available.
	assign issue = (state_q == ST_SCAN) && (iss_q < n_q);

	assign tag_rd    = lbc_pkg::tag_entry_t'(tag_rd_raw);
	assign tag_match = valid_q[ev_idx_q] && (tag_rd.disk == disk_q) && (tag_rd.block == block_q);

	// Age key: an empty entry is older than every stamp; ties move the victim
	// to the higher index because the scan runs upward and uses less-or-equal.
	assign ev_key = valid_q[ev_idx_q] ? ({1'b0, tag_rd.stamp} + KEY_W'(1)) : '0;
	assign older  = (ev_key <= best_q);

	assign target   = found_q ? hit_idx_q : victim_q;
	assign get_miss = (act_q == lbc_pkg::ACT_GET) && !found_q;
	assign commit   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// Every hit or fill rewrites the tag word with a fresh stamp; the tag
	// itself is either unchanged (hit) or the new one (fill).
	assign tag_wr.disk  = disk_q;
	assign tag_wr.block = block_q;
	assign tag_wr.stamp = use_clock_q;
	assign tag_we       = commit && !get_miss;
	assign pay_we       = commit && (act_q == lbc_pkg::ACT_PUT);
	assign pay_re       = (state_q == ST_FETCH) && (act_q == lbc_pkg::ACT_GET) && found_q;

	lbc_ram #(
		.WIDTH(lbc_pkg::TAG_ENTRY_W),
		.DEPTH(lbc_pkg::CAPACITY)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (target),
		.wdata (tag_wr),
		.re    (issue),
		.raddr (iss_q[IDX_W-1:0]),
		.rdata (tag_rd_raw)
	);

	lbc_ram #(
		.WIDTH(lbc_pkg::PAYLOAD_BITS),
		.DEPTH(lbc_pkg::CAPACITY)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (target),
		.wdata (data_q),
		.re    (pay_re),
		.raddr (hit_idx_q),
		.rdata (pay_rd)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entries_q   <= lbc_pkg::ENTRIES_RESET;
			valid_q     <= '0;
			use_clock_q <= '0;
			out_valid_q <= 1'b0;
			ev_vld_q    <= 1'b0;
			iss_q       <= '0;
		end else begin
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			// A new result may replace the one leaving in the same cycle.
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q  <= ST_SCAN;
						iss_q    <= '0;
						ev_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					ev_vld_q <= issue;
					if (issue) begin
						iss_q <= iss_q + CNT_W'(1);
					end else if (ev_vld_q) begin
						// Last entry compared this cycle.
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (!get_miss) begin
							valid_q[target] <= 1'b1;
							use_clock_q     <= use_clock_q + lbc_pkg::STAMP_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and scan datapath registers.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			act_q     <= action;
			disk_q    <= disk_id;
			block_q   <= block_id;
			data_q    <= write_data[lbc_pkg::PAYLOAD_BITS-1:0];
			n_q       <= n_clamped;
			found_q   <= 1'b0;
			hit_idx_q <= '0;
			best_q    <= '1;
			victim_q  <= '0;
		end
		if (issue) begin
			ev_idx_q <= iss_q[IDX_W-1:0];
		end
		if ((state_q == ST_SCAN) && ev_vld_q) begin
			// A later match overrides an earlier one, so duplicates resolve
			// to the highest index.
			if (tag_match) begin
				found_q   <= 1'b1;
				hit_idx_q <= ev_idx_q;
			end
			if (older) begin
				best_q   <= ev_key;
				victim_q <= ev_idx_q;
			end
		end
		if (commit) begin
			hit_q <= found_q;
			if ((act_q == lbc_pkg::ACT_GET) && found_q) begin
				read_data_q <= lbc_pkg::DATA_W'(pay_rd);
			end else begin
				read_data_q <= '0;
			end
			slot_q <= get_miss ? '0 : lbc_pkg::SLOT_W'(target);
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign read_data = read_data_q;
	assign slot      = slot_q;
endmodule

/* rtl/lbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* tb/sv/lru_block_cache_unit_tb.sv */
// Self-checking testbench for the fully associative LRU block cache.
`timescale 1ns / 1ps
module lru_block_cache_unit_tb;
	localparam int CAPACITY = lbc_pkg::CAPACITY;
	localparam int CFG_W    = lbc_pkg::CFG_W;
	localparam int DISK_W   = lbc_pkg::DISK_W;
	localparam int BLOCK_W  = lbc_pkg::BLOCK_W;
	localparam int DATA_W   = lbc_pkg::DATA_W;
	localparam int SLOT_W   = lbc_pkg::SLOT_W;
	localparam int STAMP_W  = lbc_pkg::STAMP_W;
	localparam int KEY_W    = lbc_pkg::KEY_W;
	localparam logic ACT_PUT = lbc_pkg::ACT_PUT;
	localparam logic ACT_GET = lbc_pkg::ACT_GET;

	// A no-traffic stretch longer than this means the block has hung.
	// The longest legal one is the forced receiver hold-off plus one full scan.
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	// Cycles to let pass once the last result is in, to cover any wind-down
	// after the output beat.
	localparam int SETTLE      = 8;
	localparam int POOL_MAX    = 128;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 48;

	typedef struct packed {
		logic               action;
		logic [DISK_W-1:0]  disk;
		logic [BLOCK_W-1:0] block;
		logic [DATA_W-1:0]  data;
	} access_t;

	typedef struct packed {
		logic               hit;
		logic [DATA_W-1:0]  rdata;
		logic [SLOT_W-1:0]  slot;
	} reply_t;

	// Every input starts at a known value; reset then takes over.
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic               action     = ACT_PUT;
	logic [DISK_W-1:0]  disk_id    = '0;
	logic [BLOCK_W-1:0] block_id   = '0;
	logic [DATA_W-1:0]  write_data = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic               hit;
	logic [DATA_W-1:0]  read_data;
	logic [SLOT_W-1:0]  slot;

	lru_block_cache_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.disk_id    (disk_id),
		.block_id   (block_id),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.read_data  (read_data),
		.slot       (slot)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the cache contents, kept in step with accepted beats.
	logic               shadow_valid [CAPACITY];
	logic [DISK_W-1:0]  shadow_disk  [CAPACITY];
	logic [BLOCK_W-1:0] shadow_block [CAPACITY];
	logic [DATA_W-1:0]  shadow_data  [CAPACITY];
	logic [STAMP_W-1:0] shadow_stamp [CAPACITY];
	logic [STAMP_W-1:0] use_clock;
	int                 entries_cfg;

	access_t pending_q [$];    // beats waiting for the driver
	reply_t  reply_q   [$];    // predicted replies, oldest first

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_off_req   = 1'b0;
	int  hold_cnt;
	int  quiet_cycles;
	int  errors      = 0;
	int  n_puts      = 0;
	int  n_gets      = 0;
	int  n_hits      = 0;
	int  n_settings  = 0;

	logic [DISK_W-1:0]  pool_disk  [POOL_MAX];
	logic [BLOCK_W-1:0] pool_block [POOL_MAX];
	int                 pool_size;

	access_t next_beat;
	access_t taken_beat;
	reply_t  want;

	function automatic void stamp_entry(int way);
		shadow_stamp[way] = use_clock;
		use_clock = use_clock + 1'b1;
	endfunction

	// Computes the reply for one access and applies its side effects to the
	// shadow cache. A fill looks for the smallest age key: zero for an empty
	// entry, stamp + 1 for a valid one, so empties always lose first. The <=
	// comparison hands ties to the highest index.
	function automatic reply_t cache_access(access_t a);
		int               span;
		int               way;
		int               match_way;
		int               victim;
		bit               found;
		logic [KEY_W-1:0] age;
		logic [KEY_W-1:0] oldest;
		reply_t           r;
		span = (entries_cfg == 0) ? 1 : (entries_cfg > CAPACITY) ? CAPACITY : entries_cfg;
		found = 1'b0;
		match_way = 0;
		// Stale duplicates can exist after the entry count is raised; the
		// last match in index order is the one that counts.
		for (way = 0; way < span; way++) begin
			if (shadow_valid[way] && shadow_disk[way] == a.disk && shadow_block[way] == a.block) begin
				found = 1'b1;
				match_way = way;
			end
		end
		r = '0;
		r.hit = found;
		if (a.action == ACT_GET) begin
			if (found) begin
				r.rdata = shadow_data[match_way];
				r.slot  = SLOT_W'(match_way);
				stamp_entry(match_way);
			end
		end else if (found) begin
			shadow_data[match_way] = a.data;
			r.slot = SLOT_W'(match_way);
			stamp_entry(match_way);
		end else begin
			oldest = '1;
			victim = 0;
			for (way = 0; way < span; way++) begin
				age = shadow_valid[way] ? {1'b0, shadow_stamp[way]} + 1'b1 : '0;
				if (age <= oldest) begin
					oldest = age;
					victim = way;
				end
			end
			shadow_valid[victim] = 1'b1;
			shadow_disk[victim]  = a.disk;
			shadow_block[victim] = a.block;
			shadow_data[victim]  = a.data;
			r.slot = SLOT_W'(victim);
			stamp_entry(victim);
		end
		return r;
	endfunction

	// Driver: predicts each beat as it is accepted, then loads the next one
	// only when the current beat is gone, so valid never drops early.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				taken_beat = '{action, disk_id, block_id, write_data};
				reply_q.push_back(cache_access(taken_beat));
				if (taken_beat.action == ACT_GET) n_gets++;
				else n_puts++;
			end
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = pending_q.pop_front();
					in_valid   <= 1'b1;
					action     <= next_beat.action;
					disk_id    <= next_beat.disk;
					block_id   <= next_beat.block;
					write_data <= next_beat.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker. A hold-off request parks out_ready low for a
	// long stretch so the block backs up and has to stall its input side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result beat with nothing expected: hit=%0b data=%h slot=%0d",
							hit, read_data, slot);
				end else begin
					want = reply_q.pop_front();
					if (hit === 1'b1) n_hits++;
					if (hit !== want.hit || read_data !== want.rdata || slot !== want.slot) begin
						errors++;
						if (errors <= 10)
							$display("wrong result: expected hit=%0b data=%h slot=%0d, got hit=%0b data=%h slot=%0d",
								want.hit, want.rdata, want.slot, hit, read_data, slot);
					end
				end
			end
			if (hold_cnt != 0) begin
				out_ready <= 1'b0;
				hold_cnt  <= hold_cnt - 1;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				hold_cnt  <= HOLD_CYCLES;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on stretches with no beat on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("lru_block_cache_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_access(logic act, logic [DISK_W-1:0] d, logic [BLOCK_W-1:0] b,
		logic [DATA_W-1:0] w);
		access_t a;
		a = '{act, d, b, w};
		pending_q.push_back(a);
	endtask

	// Returns once everything queued has been sent and answered, plus a
	// settling wait for the block to get back to idle.
	task automatic wait_idle();
		do @(negedge clk); while (pending_q.size() != 0 || in_valid || reply_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Only called with the block idle, so the shadow copy can follow at once.
	task automatic set_entries(int count);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(count);
		@(posedge clk);
		cfg_we    <= 1'b0;
		entries_cfg = count;
		n_settings++;
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
			default: begin send_idle_pct = 26; recv_stall_pct = 26; end
		endcase
	endtask

	// A tag pool about half again as large as the searched range keeps the
	// hit rate useful while still forcing regular evictions.
	task automatic build_pool(int count);
		int span;
		int k;
		span = (count == 0) ? 1 : (count > CAPACITY) ? CAPACITY : count;
		pool_size = span + span / 2 + 2;
		for (k = 0; k < pool_size; k++) begin
			case ($urandom_range(7))
				0: pool_disk[k] = '0;
				1: pool_disk[k] = '1;
				default: pool_disk[k] = DISK_W'($urandom_range(255));
			endcase
			case ($urandom_range(7))
				0: pool_block[k] = '0;
				1: pool_block[k] = '1;
				default: pool_block[k] = BLOCK_W'($urandom_range(65535));
			endcase
		end
	endtask

	task automatic random_access();
		int               pick;
		logic [DATA_W-1:0] w;
		case ($urandom_range(15))
			0: w = '0;
			1: w = '1;
			default: w = {$urandom, $urandom};
		endcase
		if ($urandom_range(99) < 85) begin
			pick = $urandom_range(pool_size - 1);
			queue_access($urandom_range(1) ? ACT_GET : ACT_PUT, pool_disk[pick], pool_block[pick], w);
		end else begin
			queue_access($urandom_range(1) ? ACT_GET : ACT_PUT, DISK_W'($urandom_range(255)),
				BLOCK_W'($urandom_range(65535)), w);
		end
	endtask

	initial begin
		int ph;
		int k;
		int count;
		int phase_cfg [RANDOM_PHASES];
		phase_cfg = '{1, 2, 3, 8, 16, 33, 64, 127, 0, 0, 5, 64};
		for (k = 0; k < CAPACITY; k++) shadow_valid[k] = 1'b0;
		use_clock   = '0;
		entries_cfg = lbc_pkg::ENTRIES_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset value of 64 entries: extremes of tag and data, a put hit that
		// overwrites, and misses that share only part of a stored tag.
		set_idling(0);
		queue_access(ACT_PUT, 8'h00, 16'h0000, 64'h0);
		queue_access(ACT_PUT, 8'hFF, 16'hFFFF, '1);
		queue_access(ACT_GET, 8'h00, 16'h0000, '1);
		queue_access(ACT_GET, 8'hFF, 16'hFFFF, 64'h0);
		queue_access(ACT_GET, 8'h01, 16'h0000, 64'h0);
		queue_access(ACT_PUT, 8'hFF, 16'hFFFF, 64'hA5A5_5A5A_0F0F_F0F0);
		queue_access(ACT_GET, 8'hFF, 16'hFFFF, 64'h0);
		queue_access(ACT_PUT, 8'hAA, 16'h5555, 64'h5555_5555_5555_5555);
		queue_access(ACT_GET, 8'h55, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_access(ACT_GET, 8'hAA, 16'hAAAA, 64'h0);
		wait_idle();

		// Four entries: fill them, refresh one with a get, then force an
		// eviction and confirm the least recently used tag is gone. The last
		// put plants a second copy of a tag still living at the top entry.
		set_entries(4);
		queue_access(ACT_PUT, 8'h01, 16'h0001, 64'h11);
		queue_access(ACT_PUT, 8'h01, 16'h0002, 64'h22);
		queue_access(ACT_PUT, 8'h01, 16'h0003, 64'h33);
		queue_access(ACT_PUT, 8'h01, 16'h0004, 64'h44);
		queue_access(ACT_GET, 8'h01, 16'h0001, 64'h0);
		queue_access(ACT_PUT, 8'h01, 16'h0005, 64'h55);
		queue_access(ACT_GET, 8'h01, 16'h0002, 64'h0);
		queue_access(ACT_PUT, 8'h00, 16'h0000, 64'hDEAD_BEEF_0000_0001);
		wait_idle();

		// Zero entries behaves as one: every put that misses replaces entry zero.
		set_entries(0);
		queue_access(ACT_PUT, 8'h02, 16'h0001, 64'h1);
		queue_access(ACT_PUT, 8'h02, 16'h0002, 64'h2);
		queue_access(ACT_GET, 8'h02, 16'h0001, 64'h0);
		queue_access(ACT_GET, 8'h02, 16'h0002, 64'h0);
		wait_idle();

		// A count above capacity clamps to 64, which brings the duplicated tag
		// back into range: the higher copy must win and only it is updated.
		set_entries(127);
		queue_access(ACT_GET, 8'h00, 16'h0000, 64'h0);
		queue_access(ACT_PUT, 8'h00, 16'h0000, 64'h0123_4567_89AB_CDEF);
		queue_access(ACT_GET, 8'h00, 16'h0000, 64'h0);
		wait_idle();

		// Random phases over a spread of entry counts and idling patterns.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			count = (ph == 9) ? $urandom_range(127) : phase_cfg[ph];
			set_entries(count);
			set_idling(ph);
			build_pool(count);
			if (ph == 4) begin
				// Long receiver hold-off with the sender running flat out.
				send_idle_pct = 0;
				hold_off_req = 1'b1;
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				random_access();
				// Halfway through one phase the sender stops and lets the
				// block drain completely before carrying on.
				if (ph == 10 && k == PHASE_ITEMS / 2) wait_idle();
			end
			wait_idle();
		end

		$display("Ran %0d puts and %0d gets, %0d of them hits, across %0d entry-count settings",
			n_puts, n_gets, n_hits, n_settings);
		$display("with free-running, sender-idle, receiver-stall and mixed traffic phases.");
		if (errors == 0) begin
			$display("lru_block_cache_unit: match");
		end else begin
			$display("lru_block_cache_unit: mismatch");
		end
		$finish;
	end
endmodule

/* sim.f */
rtl/lbc_pkg.sv
rtl/lbc_ram.sv
rtl/lru_block_cache_unit.sv
tb/sv/lru_block_cache_unit_tb.sv
